// ===== design/mme_pkg.sv =====
package mme_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 3'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // Controller to datapath: store writes and one inner-product beat.
    typedef struct packed {
        logic             we_a;
        logic             we_b;
        logic             beat;
        logic             zero;
        logic             first;
        logic             last_p;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] p;
        logic             final_elem;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

// ===== design/mme_item_if.sv =====
interface mme_item_if import mme_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, command, row, col, value, input ready);
    modport sink   (input valid, command, row, col, value, output ready);
endinterface

// ===== design/mme_result_if.sv =====
interface mme_result_if import mme_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last;

    modport source (output valid, result, out_row, out_col, last, input ready);
    modport sink   (input valid, result, out_row, out_col, last, output ready);
endinterface

// ===== design/mme_cfg_if.sv =====
interface mme_cfg_if import mme_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mme_ram.sv =====
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mme_ctrl.sv =====
module mme_ctrl import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [IDX_W-1:0]     i_row,
    input  logic [IDX_W-1:0]     i_col,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_dp_status           i_status,
    output t_dp_cmd              o_cmd
);

    localparam logic [CFG_W-1:0] DIM = CFG_W'(MAX_DIM);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_p, n_p;

    logic [CFG_W-1:0] r_row_start;
    logic [CFG_W-1:0] r_row_end;
    logic [CFG_W-1:0] r_inner_size;
    logic [CFG_W-1:0] r_col_count;

    logic [CFG_W-1:0] w_rend;
    logic [CFG_W-1:0] w_kk;
    logic [CFG_W-1:0] w_cc;
    logic             w_in_fire;
    logic             w_in_range;
    logic             w_last_p;
    logic             w_last_j;
    logic             w_final;

    assign w_rend = (r_row_end > DIM) ? DIM : r_row_end;
    assign w_kk   = (r_inner_size > DIM) ? DIM : r_inner_size;
    assign w_cc   = (r_col_count > DIM) ? DIM : r_col_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_start  <= CFG_W'(0);
            r_row_end    <= CFG_W'(8);
            r_inner_size <= CFG_W'(8);
            r_col_count  <= CFG_W'(8);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_START:  r_row_start  <= i_cfg_data;
                CFG_ROW_END:    r_row_end    <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COL_COUNT:  r_col_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_p     <= n_p;
        end
    end

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_in_range = ({1'b0, i_row} < DIM) && ({1'b0, i_col} < DIM);
    // An inner size of zero still runs one beat, which forces a zero product.
    assign w_last_p   = (w_kk == '0) || (({1'b0, r_p} + CFG_W'(1)) == w_kk);
    assign w_last_j   = ({1'b0, r_j} + CFG_W'(1)) == w_cc;
    assign w_final    = w_last_j && (({1'b0, r_i} + CFG_W'(1)) == w_rend);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_p        = r_p;
        o_in_ready = 1'b0;

        o_cmd            = '0;
        o_cmd.i          = r_i;
        o_cmd.j          = r_j;
        o_cmd.p          = r_p;
        o_cmd.zero       = (w_kk == '0);
        o_cmd.first      = (r_p == '0);
        o_cmd.last_p     = w_last_p;
        o_cmd.final_elem = w_final;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_fire) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD_A: o_cmd.we_a = w_in_range;
                        CMD_LOAD_B: o_cmd.we_b = w_in_range;
                        CMD_COMPUTE: begin
                            if ((r_row_start < w_rend) && (w_cc != '0)) begin
                                n_i     = IDX_W'(r_row_start);
                                n_j     = '0;
                                n_p     = '0;
                                n_state = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.beat = 1'b1;
                if (w_last_p) begin
                    n_state = ST_WAIT;
                end else begin
                    n_p = r_p + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    n_p = '0;
                    if (w_final) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                        if (w_last_j) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== design/mme_datapath.sv =====
module mme_datapath import mme_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_result,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic                     o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    // Room for MAX_DIM full products without overflow.
    localparam int ACC_W = PROD_W + $clog2(MAX_DIM);

    logic [AW-1:0]            w_waddr;
    logic [AW-1:0]            w_a_raddr;
    logic [AW-1:0]            w_b_raddr;
    logic                     w_re;
    logic signed [DATA_W-1:0] w_a_rdata;
    logic signed [DATA_W-1:0] w_b_rdata;

    logic r_s1_vld, r_s1_zero, r_s1_first, r_s1_last;
    logic r_s2_vld, r_s2_first, r_s2_last;
    logic r_s3_last;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_hold_vld;
    logic signed [DATA_W-1:0] r_hold_res;
    logic [IDX_W-1:0]         r_hold_row;
    logic [IDX_W-1:0]         r_hold_col;
    logic                     r_hold_last;

    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_res;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic                     r_out_last;

    logic signed [ACC_W-1:0]  w_shift;
    logic [ACC_W-DATA_W:0]    w_upper;
    logic signed [DATA_W-1:0] w_sat;
    logic                     w_move;

    assign w_waddr   = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);
    assign w_a_raddr = AW'(i_cmd.i) * AW'(MAX_DIM) + AW'(i_cmd.p);
    assign w_b_raddr = AW'(i_cmd.p) * AW'(MAX_DIM) + AW'(i_cmd.j);
    assign w_re      = i_cmd.beat && !i_cmd.zero;

    mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_re),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_re),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Floor shift of the exact sum, then saturate when the high bits
    // are not a plain sign extension.
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_upper = w_shift[ACC_W-1:DATA_W-1];
    assign w_sat   = ((&w_upper) || !(|w_upper)) ? w_shift[DATA_W-1:0]
                   : (w_shift[ACC_W-1] ? SAT_MIN : SAT_MAX);

    assign w_move = r_hold_vld && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_last  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_vld  <= i_cmd.beat;
            r_s2_vld  <= r_s1_vld;
            r_s3_last <= r_s2_vld && r_s2_last;
            if (r_s2_vld) begin
                r_acc <= (r_s2_first ? ACC_W'(0) : r_acc)
                       + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
            if (r_s3_last) begin
                r_hold_vld <= 1'b1;
            end else if (w_move) begin
                r_hold_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zero  <= i_cmd.zero;
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last_p;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s1_zero) begin
            r_prod <= '0;
        end else begin
            r_prod <= w_a_rdata * w_b_rdata;
        end
        // The controller holds the element indexes until the result moves on.
        if (r_s3_last) begin
            r_hold_res  <= w_sat;
            r_hold_row  <= i_cmd.i;
            r_hold_col  <= i_cmd.j;
            r_hold_last <= i_cmd.final_elem;
        end
        if (w_move) begin
            r_out_res  <= r_hold_res;
            r_out_row  <= r_hold_row;
            r_out_col  <= r_hold_col;
            r_out_last <= r_hold_last;
        end
    end

    assign o_status.done = w_move;
    assign o_out_valid   = r_out_vld;
    assign o_result      = r_out_res;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_last        = r_out_last;

endmodule

// ===== design/matrix_multiply_engine_core.sv =====
// Load items are accepted back to back while idle.
// A compute emits the C elements one at a time; each takes K = max(min(inner_size, MAX_DIM), 1)
// beats that read the stores, then the multiply, accumulate, saturate and handoff steps.
// The next element starts only after the previous one is handed off; output stalls delay it.
// Input is held off until the last element of a run has reached the output. Synchronous
// active-low reset sets the range registers to 0, 8, 8, 8; the stores are not cleared.
module matrix_multiply_engine_core import mme_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mme_item_if.sink      i_item,
    mme_result_if.source  o_result,
    mme_cfg_if.sink       i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_cfg_ready;

    mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .i_command   (i_item.command),
        .i_row       (i_item.row),
        .i_col       (i_item.col),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (w_cfg_ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mme_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row       (i_item.row),
        .i_col       (i_item.col),
        .i_value     (i_item.value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_result    (o_result.result),
        .o_out_row   (o_result.out_row),
        .o_out_col   (o_result.out_col),
        .o_last      (o_result.last)
    );

    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = w_cfg_ready;

endmodule
